@@ src/psm_pkg.sv @@
// ----------------------------------------------------------------------------
// psm_pkg
// Shared constants, command and status types of the 64-bit state mixer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package psm_pkg;

  localparam int unsigned WordW   = 64;
  localparam int unsigned NumElem = 20;
  localparam int unsigned IdxW    = 5;

  localparam logic [WordW-1:0] K_STEP = 64'd1111111111111;
  localparam logic [WordW-1:0] FIX_K1 = 64'd4692409560;
  localparam logic [WordW-1:0] FIX_K2 = 64'd301351086269144;
  localparam logic [WordW-1:0] FIX_K3 = 64'd297442264;
  localparam logic [WordW-1:0] FIX_K4 = 64'd4814950713639640;

  localparam int unsigned ROT_LANE = 19;
  localparam int unsigned ROT_ELEM = 51;
  localparam int unsigned ROT_SUM  = 47;
  localparam int unsigned ROT_MIX  = 25;

  localparam logic OP_GEN  = 1'b0;
  localparam logic OP_LOAD = 1'b1;

  localparam logic [IdxW-1:0] IDX_STEP = 5'd20;
  localparam logic [IdxW-1:0] IDX_SUM  = 5'd21;
  localparam logic [IdxW-1:0] IDX_MIX  = 5'd22;
  localparam logic [IdxW-1:0] LAST_NUM = 5'd19;

  typedef struct packed {
    logic            load;
    logic            mix_rd;
    logic [1:0]      mix_sel;
    logic            mix_cap;
    logic            adv;
    logic            lane_b;
    logic            lane_m;
    logic            el_rd;
    logic [IdxW-1:0] pos;
    logic            el_upd;
    logic            el_acc;
    logic            fix_cmp;
    logic            fix_add;
    logic            emit;
    logic [IdxW-1:0] wnum;
    logic            last;
    logic            rot;
    logic            fin;
  } cmd_t;

  typedef struct packed {
    logic emit_ok;
  } status_t;

  function automatic logic [WordW-1:0] rotl64(input logic [WordW-1:0] x,
                                              input int unsigned r);
    return (x << r) | (x >> (WordW - r));
  endfunction

endpackage

@@ src/psm_if.sv @@
// ----------------------------------------------------------------------------
// psm_in_if / psm_out_if
// Valid/ready channels for request items and generated words.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface psm_in_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [4:0]  word_index;
  logic [63:0] load_value;

  modport source (output valid, opcode, word_index, load_value, input ready);
  modport sink   (input valid, opcode, word_index, load_value, output ready);
endinterface

interface psm_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] random_word;
  logic [4:0]  word_number;
  logic        last;

  modport source (output valid, random_word, word_number, last, input ready);
  modport sink   (input valid, random_word, word_number, last, output ready);
endinterface

@@ src/psm_ram.sv @@
// ----------------------------------------------------------------------------
// psm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module psm_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 20,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/psm_ctrl.sv @@
// ----------------------------------------------------------------------------
// psm_ctrl
// Sequencer: mix word reads, four lanes of five element updates, fix-up,
// writeback and emission of each group, final counter update.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module psm_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_opcode_i,
  output logic              in_ready_o,
  input  psm_pkg::status_t  status_i,
  output psm_pkg::cmd_t     cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_MIX_RD, S_MIX_CAP, S_ADV, S_LANE_B, S_LANE_M, S_EL_RD,
    S_EL_UPD, S_EL_ACC, S_FIX_CMP, S_FIX_ADD, S_EMIT, S_ROT, S_FIN
  } state_e;

  state_e                     state_q;
  logic [2:0]                 cnt_q;
  logic [1:0]                 lane_q;
  logic [psm_pkg::IdxW-1:0]   pos_q;
  logic [psm_pkg::IdxW-1:0]   wpos_q;
  logic                       fire;

  assign in_ready_o = (state_q == S_IDLE);
  assign fire       = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      lane_q  <= '0;
      pos_q   <= '0;
      wpos_q  <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (fire && (in_opcode_i == psm_pkg::OP_GEN)) begin
            cnt_q   <= '0;
            lane_q  <= '0;
            pos_q   <= '0;
            wpos_q  <= '0;
            state_q <= S_MIX_RD;
          end
        end
        S_MIX_RD: state_q <= S_MIX_CAP;
        S_MIX_CAP: begin
          if (cnt_q == 3'd3) begin
            cnt_q   <= '0;
            state_q <= S_ADV;
          end else begin
            cnt_q   <= cnt_q + 3'd1;
            state_q <= S_MIX_RD;
          end
        end
        S_ADV:    state_q <= S_LANE_B;
        S_LANE_B: state_q <= S_LANE_M;
        S_LANE_M: state_q <= S_EL_RD;
        S_EL_RD:  state_q <= S_EL_UPD;
        S_EL_UPD: state_q <= S_EL_ACC;
        S_EL_ACC: begin
          pos_q <= pos_q + 5'd1;
          if (cnt_q == 3'd4) begin
            cnt_q   <= '0;
            state_q <= S_FIX_CMP;
          end else begin
            cnt_q   <= cnt_q + 3'd1;
            state_q <= S_EL_RD;
          end
        end
        S_FIX_CMP: state_q <= S_FIX_ADD;
        S_FIX_ADD: state_q <= S_EMIT;
        S_EMIT: begin
          if (status_i.emit_ok) begin
            wpos_q <= wpos_q + 5'd1;
            if (cnt_q == 3'd4) begin
              cnt_q   <= '0;
              state_q <= S_ROT;
            end else begin
              cnt_q <= cnt_q + 3'd1;
            end
          end
        end
        S_ROT: begin
          if (lane_q == 2'd3) begin
            state_q <= S_FIN;
          end else begin
            lane_q  <= lane_q + 2'd1;
            state_q <= S_LANE_B;
          end
        end
        S_FIN:   state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd_o         = '0;
    cmd_o.load    = fire && (in_opcode_i == psm_pkg::OP_LOAD);
    cmd_o.mix_rd  = (state_q == S_MIX_RD);
    cmd_o.mix_sel = cnt_q[1:0];
    cmd_o.mix_cap = (state_q == S_MIX_CAP);
    cmd_o.adv     = (state_q == S_ADV);
    cmd_o.lane_b  = (state_q == S_LANE_B);
    cmd_o.lane_m  = (state_q == S_LANE_M);
    cmd_o.el_rd   = (state_q == S_EL_RD);
    cmd_o.pos     = pos_q;
    cmd_o.el_upd  = (state_q == S_EL_UPD);
    cmd_o.el_acc  = (state_q == S_EL_ACC);
    cmd_o.fix_cmp = (state_q == S_FIX_CMP);
    cmd_o.fix_add = (state_q == S_FIX_ADD);
    cmd_o.emit    = (state_q == S_EMIT) && status_i.emit_ok;
    cmd_o.wnum    = wpos_q;
    cmd_o.last    = (wpos_q == psm_pkg::LAST_NUM);
    cmd_o.rot     = (state_q == S_ROT);
    cmd_o.fin     = (state_q == S_FIN);
  end

endmodule

@@ src/psm_datapath.sv @@
// ----------------------------------------------------------------------------
// psm_datapath
// Element RAM, counters, mix word line, group line and output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module psm_datapath (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  psm_pkg::cmd_t               cmd_i,
  output psm_pkg::status_t            status_o,
  input  logic [psm_pkg::IdxW-1:0]    word_index_i,
  input  logic [psm_pkg::WordW-1:0]   load_value_i,
  input  logic                        out_ready_i,
  output logic                        out_valid_o,
  output logic [psm_pkg::WordW-1:0]   out_word_o,
  output logic [psm_pkg::IdxW-1:0]    out_num_o,
  output logic                        out_last_o
);

  logic [psm_pkg::WordW-1:0]   a_q, b_q, c_q;
  logic [psm_pkg::WordW-1:0]   m_q [4];
  logic [psm_pkg::WordW-1:0]   g_q [5];
  logic [psm_pkg::NumElem-1:0] seeded_q;
  logic                        rd_seeded_q;
  logic                        fix_q;
  logic                        out_valid_q;
  logic [psm_pkg::WordW-1:0]   out_word_q;
  logic [psm_pkg::IdxW-1:0]    out_num_q;
  logic                        out_last_q;

  logic                        ram_we, ram_re, elem_load;
  logic [psm_pkg::IdxW-1:0]    ram_waddr, ram_raddr;
  logic [psm_pkg::WordW-1:0]   ram_wdata, ram_rdata, rd_word, m0;
  logic [3:0]                  mix_off;

  assign m0        = m_q[0];
  assign elem_load = cmd_i.load && (word_index_i < 5'(psm_pkg::NumElem));
  assign ram_we    = elem_load || cmd_i.emit;
  assign ram_waddr = cmd_i.emit ? cmd_i.wnum : word_index_i;
  assign ram_wdata = cmd_i.emit ? g_q[0] : load_value_i;

  // Mix sources sit at a + 3*i, wrapped into the lower sixteen elements.
  assign mix_off   = {2'b00, cmd_i.mix_sel} + {1'b0, cmd_i.mix_sel, 1'b0};
  assign ram_re    = cmd_i.mix_rd || cmd_i.el_rd;
  assign ram_raddr = cmd_i.mix_rd ? {1'b0, a_q[3:0] + mix_off} : cmd_i.pos;

  // An element never written since reset reads as zero.
  assign rd_word = rd_seeded_q ? ram_rdata : '0;

  psm_ram #(
    .Width (psm_pkg::WordW),
    .Depth (psm_pkg::NumElem)
  ) u_elem_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q         <= '0;
      b_q         <= '0;
      c_q         <= '0;
      seeded_q    <= '0;
      rd_seeded_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (ram_we) begin
        seeded_q[ram_waddr] <= 1'b1;
      end
      if (ram_re) begin
        rd_seeded_q <= seeded_q[ram_raddr];
      end
      if (cmd_i.load) begin
        if (word_index_i == psm_pkg::IDX_STEP) begin
          a_q <= load_value_i;
        end else if (word_index_i == psm_pkg::IDX_SUM) begin
          b_q <= load_value_i;
        end else if (word_index_i == psm_pkg::IDX_MIX) begin
          c_q <= load_value_i;
        end
      end
      if (cmd_i.adv) begin
        a_q <= a_q + psm_pkg::K_STEP;
      end
      if (cmd_i.lane_b) begin
        b_q <= b_q + a_q;
        c_q <= c_q ^ a_q;
      end
      if (cmd_i.fin) begin
        b_q <= (b_q + psm_pkg::rotl64(m_q[0], psm_pkg::ROT_SUM)) ^ m_q[1];
        c_q <= (c_q + psm_pkg::rotl64(m_q[2], psm_pkg::ROT_MIX)) ^ m_q[3];
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mix_cap) begin
      m_q[0] <= m_q[1];
      m_q[1] <= m_q[2];
      m_q[2] <= m_q[3];
      m_q[3] <= rd_word;
    end
    if (cmd_i.lane_m) begin
      m_q[0] <= m0 + psm_pkg::rotl64(b_q, psm_pkg::ROT_LANE);
    end
    if (cmd_i.el_acc) begin
      m_q[0] <= m0 + g_q[4];
    end
    // Each lane works on the head of the line; rotating it after each of the four
    // lanes restores the original order for the final counter update.
    if (cmd_i.rot) begin
      m_q[0] <= m_q[1];
      m_q[1] <= m_q[2];
      m_q[2] <= m_q[3];
      m_q[3] <= m_q[0];
    end
    if (cmd_i.el_upd || cmd_i.emit) begin
      g_q[0] <= g_q[1];
      g_q[1] <= g_q[2];
      g_q[2] <= g_q[3];
      g_q[3] <= g_q[4];
      g_q[4] <= (rd_word + psm_pkg::rotl64(m0, psm_pkg::ROT_ELEM)) ^ c_q;
    end
    if (cmd_i.fix_cmp) begin
      fix_q <= (g_q[4] == g_q[3]) && (g_q[2] == g_q[1]);
    end
    if (cmd_i.fix_add && fix_q) begin
      g_q[4] <= g_q[4] + (m0 ^ psm_pkg::FIX_K1);
      g_q[3] <= g_q[3] + (m0 ^ psm_pkg::FIX_K2);
      g_q[2] <= g_q[2] + ((m0 ^ psm_pkg::FIX_K3) | {63'd0, m0[0]});
      g_q[1] <= g_q[1] + (m0 ^ psm_pkg::FIX_K4);
      g_q[0] <= g_q[0] + m0;
    end
    if (cmd_i.emit) begin
      out_word_q <= g_q[0];
      out_num_q  <= cmd_i.wnum;
      out_last_q <= cmd_i.last;
    end
  end

  assign status_o.emit_ok = !out_valid_q || out_ready_i;
  assign out_valid_o      = out_valid_q;
  assign out_word_o       = out_word_q;
  assign out_num_o        = out_num_q;
  assign out_last_o       = out_last_q;

endmodule

@@ src/prng_state_mixer_64.sv @@
// ----------------------------------------------------------------------------
// prng_state_mixer_64
// Timing: a load item takes effect when accepted; a generate item shows its
// first word after the mix reads, the first lane and its fix-up, and blocks
// the input until its final counter update. The pace is set by the serial
// element read, update and accumulate steps and the five-step update chain in
// each of four lanes; receiver stalls while a group is emitted hold it back.
// Reset: counters clear and all elements read as zero until written.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module prng_state_mixer_64 (
  input  logic        clk_i,
  input  logic        rst_ni,
  psm_in_if.sink      in_i,
  psm_out_if.source   out_o
);

  psm_pkg::cmd_t    cmd;
  psm_pkg::status_t status;

  psm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_opcode_i (in_i.opcode),
    .in_ready_o  (in_i.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  psm_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .word_index_i (in_i.word_index),
    .load_value_i (in_i.load_value),
    .out_ready_i  (out_o.ready),
    .out_valid_o  (out_o.valid),
    .out_word_o   (out_o.random_word),
    .out_num_o    (out_o.word_number),
    .out_last_o   (out_o.last)
  );

`ifndef NO_ASSERTIONS
  a_gen_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready && (in_i.opcode == psm_pkg::OP_GEN)) |=> !in_i.ready)
    else $error("generate item accepted but block not busy");

  a_last_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.last) |-> (out_o.word_number == psm_pkg::LAST_NUM))
    else $error("last flag on a word other than the twentieth");

  a_emit_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_o.valid) |-> !$past(in_i.ready))
    else $error("output word produced while block was idle");
`endif

endmodule
